@@ src/assert_macros.svh @@
// Assertion macros shared by the fan duty RTL.
// Each macro checks on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define FDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset
`define FDT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/fdt_pkg.sv @@
// Shared types, constants and helpers for the fan duty from temperature block.
// No dependencies; used by every module of the block.
package fdt_pkg;

  localparam int TEMP_W = 12;
  localparam int CMD_W  = 10;
  localparam int HYST_W = 9;
  localparam int NUM_W  = 22;   // (temperature difference) * 1000
  localparam int QUO_W  = 10;   // ramp quotient is always below 1000
  localparam int RSN_W  = 3;

  localparam logic [CMD_W-1:0] CMD_FULL    = CMD_W'(1000);
  localparam logic [CMD_W-1:0] CMD_OFF     = '0;
  localparam logic [CMD_W-1:0] RUN_THRESH  = CMD_W'(5);
  localparam logic [CMD_W-1:0] RAMP_SCALE  = CMD_W'(1000);

  typedef logic [RSN_W-1:0] reason_t;

  localparam reason_t RS_OFF_COOL    = 3'd0;
  localparam reason_t RS_RAMP        = 3'd1;
  localparam reason_t RS_MIN_HYST    = 3'd2;
  localparam reason_t RS_CHARGE_WARM = 3'd3;
  localparam reason_t RS_HOT_LIMIT   = 3'd4;
  localparam reason_t RS_INVALID     = 3'd5;
  localparam reason_t RS_FAULT       = 3'd6;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RAMP_START  = 3'd0;
  localparam logic [2:0] REG_FULL_SPEED  = 3'd1;
  localparam logic [2:0] REG_OFF_HYST    = 3'd2;
  localparam logic [2:0] REG_MIN_CMD     = 3'd3;
  localparam logic [2:0] REG_CHARGE_WARM = 3'd4;

  typedef struct packed {
    logic signed [TEMP_W-1:0] ramp_start_temp;
    logic signed [TEMP_W-1:0] full_speed_temp;
    logic [HYST_W-1:0]        off_hysteresis;
    logic [CMD_W-1:0]         min_command;
    logic [CMD_W-1:0]         charge_warm_command;
  } cfg_regs_t;

  // Saturate a command register to full scale
  function automatic logic [CMD_W-1:0] sat_cmd(input logic [CMD_W-1:0] v);
    sat_cmd = (v > CMD_FULL) ? CMD_FULL : v;
  endfunction

endpackage

@@ src/fdt_cfg_regs.sv @@
// APB-style configuration register bank for the fan duty block.
// Depends on fdt_pkg for register indexes and the register struct.
module fdt_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output fdt_pkg::cfg_regs_t regs
);

  fdt_pkg::cfg_regs_t regs_r;
  logic               wr_en;
  logic [2:0]         idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign regs       = regs_r;

  // Register writes; unknown addresses are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.ramp_start_temp     <= 12'sd400;
      regs_r.full_speed_temp     <= 12'sd550;
      regs_r.off_hysteresis      <= 9'd30;
      regs_r.min_command         <= 10'd200;
      regs_r.charge_warm_command <= 10'd300;
    end else if (wr_en) begin
      case (idx)
        fdt_pkg::REG_RAMP_START:  regs_r.ramp_start_temp     <= cfg_pwdata[11:0];
        fdt_pkg::REG_FULL_SPEED:  regs_r.full_speed_temp     <= cfg_pwdata[11:0];
        fdt_pkg::REG_OFF_HYST:    regs_r.off_hysteresis      <= cfg_pwdata[8:0];
        fdt_pkg::REG_MIN_CMD:     regs_r.min_command         <= cfg_pwdata[9:0];
        fdt_pkg::REG_CHARGE_WARM: regs_r.charge_warm_command <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read-back mux, zero extended
  always_comb begin
    case (idx)
      fdt_pkg::REG_RAMP_START:  cfg_prdata = {20'd0, regs_r.ramp_start_temp};
      fdt_pkg::REG_FULL_SPEED:  cfg_prdata = {20'd0, regs_r.full_speed_temp};
      fdt_pkg::REG_OFF_HYST:    cfg_prdata = {23'd0, regs_r.off_hysteresis};
      fdt_pkg::REG_MIN_CMD:     cfg_prdata = {22'd0, regs_r.min_command};
      fdt_pkg::REG_CHARGE_WARM: cfg_prdata = {22'd0, regs_r.charge_warm_command};
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

@@ src/fdt_div.sv @@
// Restoring divider for the fan ramp: one shared subtract/compare per cycle.
// Depends on fdt_pkg for widths. Needs num / den below 2**QUO_W.
module fdt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fdt_pkg::NUM_W-1:0]  num,
  input  logic [fdt_pkg::TEMP_W-1:0] den,
  output logic                       done,
  output logic [fdt_pkg::QUO_W-1:0]  quot
);

  localparam int REM_W = fdt_pkg::NUM_W - fdt_pkg::QUO_W;
  localparam int CNT_W = $clog2(fdt_pkg::QUO_W + 1);

  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [fdt_pkg::QUO_W-1:0] q_r, q_nxt;
  logic [fdt_pkg::TEMP_W-1:0] den_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [REM_W:0]            shifted;
  logic [REM_W:0]            trial;

  // One quotient bit per step: shift in the next dividend bit, try the subtract
  assign shifted = {rem_r, q_r[fdt_pkg::QUO_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // High dividend bits are already below the divisor
      rem_nxt  = num[fdt_pkg::NUM_W-1:fdt_pkg::QUO_W];
      q_nxt    = num[fdt_pkg::QUO_W-1:0];
      cnt_nxt  = CNT_W'(fdt_pkg::QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[REM_W]) begin
        rem_nxt = trial[REM_W-1:0];
        q_nxt   = {q_r[fdt_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[REM_W-1:0];
        q_nxt   = {q_r[fdt_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ src/fan_duty_from_temperature_core.sv @@
// Top level of the fan duty from temperature block.
// Depends on fdt_pkg, fdt_cfg_regs, fdt_div and assert_macros.svh.

// Fan duty from temperature: one temperature report in, one fan command (0.1 %)
// and reason code out per transfer. A fixed command (invalid, fault, full, off or
// inside the hysteresis band) is set in classification and then loaded into the
// output register. On the linear ramp a report passes through classification,
// which also forms (temp - start) * 1000 with a 12x10 multiply, then the divider
// load, 10 restoring divide steps, the floors applied to the quotient and the
// output register load, which waits while the output register holds an untaken
// result. One report is in work at a time; in_tready rises the cycle after the
// result is loaded and is high while the block is idle, even while a finished
// result still waits in the output register. Configuration is written over the
// APB-style port and is read live by the sequencer, also for the report in work.

`include "assert_macros.svh"

module fan_duty_from_temperature_core (
  input  logic        clk,
  input  logic        rst_n,
  // APB-style configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // Temperature report stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] cell_temp, [12] temp_ok, [13] read_fault, [21:14] usable_sensors,
  // [22] overtemp_fault, [23] force_full, [24] charging, [25] driver_faulted
  input  logic [31:0] in_tdata,
  // Fan command stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [9:0] fan_command, [12:10] reason
  output logic [15:0] out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MUL,
    S_DIV,
    S_PUT
  } state_t;

  localparam int TW = fdt_pkg::TEMP_W;
  localparam int CW = fdt_pkg::CMD_W;

  fdt_pkg::cfg_regs_t regs;

  state_t                 state_r, state_nxt;
  logic signed [TW-1:0]   temp_r;
  logic                   ok_r, rfault_r, ofault_r, full_r, chg_r, drv_r;
  logic [7:0]             sensors_r;
  logic [CW-1:0]          cmd_r, cmd_nxt;
  fdt_pkg::reason_t       rsn_r, rsn_nxt;
  logic [CW-1:0]          last_cmd_r;
  fdt_pkg::reason_t       last_rsn_r;
  logic [fdt_pkg::NUM_W-1:0] prod_r, prod_nxt;
  logic [TW-1:0]          span_r, span_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CW-1:0]          out_cmd_r, out_cmd_nxt;
  fdt_pkg::reason_t       out_rsn_r, out_rsn_nxt;
  logic                   upd_last;

  logic                   in_xfer;
  logic                   invalid, running;
  logic signed [TW:0]     t_ext, start_ext, full_ext, off_pt, diff, span;
  logic [CW-1:0]          min_cmd, warm_cmd, ramp_cmd;
  logic                   div_start, div_done;
  logic [fdt_pkg::QUO_W-1:0] div_quot;
  logic                   out_forced;

  fdt_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  fdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign div_start = (state_r == S_MUL);

  // Temperatures widened by one bit so differences cannot wrap
  assign t_ext     = {temp_r[TW-1], temp_r};
  assign start_ext = {regs.ramp_start_temp[TW-1], regs.ramp_start_temp};
  assign full_ext  = {regs.full_speed_temp[TW-1], regs.full_speed_temp};
  assign off_pt    = start_ext - $signed({4'd0, regs.off_hysteresis});
  assign diff      = t_ext - start_ext;
  assign span      = full_ext - start_ext;
  assign min_cmd   = fdt_pkg::sat_cmd(regs.min_command);
  assign warm_cmd  = fdt_pkg::sat_cmd(regs.charge_warm_command);
  assign invalid   = !ok_r || rfault_r || (sensors_r == 8'd0);
  assign running   = (last_cmd_r > fdt_pkg::RUN_THRESH) && !drv_r &&
                     !(last_rsn_r inside {fdt_pkg::RS_HOT_LIMIT, fdt_pkg::RS_INVALID,
                                          fdt_pkg::RS_FAULT});

  // Ramp quotient clamped to full scale and floored at the minimum command
  always_comb begin
    ramp_cmd = CW'(div_quot);
    if (ramp_cmd > fdt_pkg::CMD_FULL) begin
      ramp_cmd = fdt_pkg::CMD_FULL;
    end
    if (ramp_cmd < min_cmd) begin
      ramp_cmd = min_cmd;
    end
  end

  // Sequencer next-state and result selection
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    rsn_nxt       = rsn_r;
    prod_nxt      = prod_r;
    span_nxt      = span_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_cmd_nxt   = out_cmd_r;
    out_rsn_nxt   = out_rsn_r;
    upd_last      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_PUT;
        if (invalid) begin
          cmd_nxt = fdt_pkg::CMD_FULL;
          rsn_nxt = fdt_pkg::RS_INVALID;
        end else if (ofault_r) begin
          cmd_nxt = fdt_pkg::CMD_FULL;
          rsn_nxt = fdt_pkg::RS_FAULT;
        end else if (full_r || (t_ext >= full_ext) || (full_ext <= start_ext)) begin
          cmd_nxt = fdt_pkg::CMD_FULL;
          rsn_nxt = fdt_pkg::RS_HOT_LIMIT;
        end else if (t_ext <= off_pt) begin
          cmd_nxt = fdt_pkg::CMD_OFF;
          rsn_nxt = fdt_pkg::RS_OFF_COOL;
        end else if (t_ext <= start_ext) begin
          if (running) begin
            cmd_nxt = min_cmd;
            rsn_nxt = fdt_pkg::RS_MIN_HYST;
          end else if (chg_r) begin
            cmd_nxt = warm_cmd;
            rsn_nxt = fdt_pkg::RS_CHARGE_WARM;
          end else begin
            cmd_nxt = fdt_pkg::CMD_OFF;
            rsn_nxt = fdt_pkg::RS_OFF_COOL;
          end
        end else begin
          // On the ramp: both differences are positive and fit TEMP_W bits
          prod_nxt  = fdt_pkg::NUM_W'(diff[TW-1:0]) * fdt_pkg::NUM_W'(fdt_pkg::RAMP_SCALE);
          span_nxt  = span[TW-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_PUT;
          if (chg_r && (ramp_cmd < warm_cmd)) begin
            cmd_nxt = warm_cmd;
            rsn_nxt = fdt_pkg::RS_CHARGE_WARM;
          end else begin
            cmd_nxt = ramp_cmd;
            rsn_nxt = fdt_pkg::RS_RAMP;
          end
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cmd_nxt   = cmd_r;
          out_rsn_nxt   = rsn_r;
          upd_last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, kept command history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_cmd_r  <= '0;
      last_rsn_r  <= fdt_pkg::RS_OFF_COOL;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_last) begin
        last_cmd_r <= cmd_r;
        last_rsn_r <= rsn_r;
      end
    end
    cmd_r     <= cmd_nxt;
    rsn_r     <= rsn_nxt;
    prod_r    <= prod_nxt;
    span_r    <= span_nxt;
    out_cmd_r <= out_cmd_nxt;
    out_rsn_r <= out_rsn_nxt;
    if (in_xfer) begin
      temp_r    <= in_tdata[11:0];
      ok_r      <= in_tdata[12];
      rfault_r  <= in_tdata[13];
      sensors_r <= in_tdata[21:14];
      ofault_r  <= in_tdata[22];
      full_r    <= in_tdata[23];
      chg_r     <= in_tdata[24];
      drv_r     <= in_tdata[25];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_rsn_r, out_cmd_r};

  // Reasons that always come with full speed
  assign out_forced = out_rsn_r inside {fdt_pkg::RS_INVALID, fdt_pkg::RS_FAULT,
                                        fdt_pkg::RS_HOT_LIMIT};

  // Checks
  `FDT_ASSERT(a_busy_after_xfer, in_xfer |=> !in_tready, "accepted a report while busy")
  `FDT_ASSERT_NEVER(a_div_done_state, div_done && (state_r != S_DIV), "divider out of turn")
  `FDT_ASSERT(a_cmd_range, out_valid_r |-> (out_cmd_r <= fdt_pkg::CMD_FULL), "command too high")
  `FDT_ASSERT(a_full_reason, out_valid_r && out_forced |-> (out_cmd_r == fdt_pkg::CMD_FULL), "forced reason without full command")

endmodule

@@ bench/tb_fan_duty_from_temperature_core.sv @@
// Testbench for fan_duty_from_temperature_core: directed and random temperature reports,
// with each fan command checked against a cycle-free predictor of the fan curve.
// Depends on fdt_pkg and the fan_duty_from_temperature_core RTL.
module tb_fan_duty_from_temperature_core;

  localparam int STALL_LIMIT = 4000;   // cycles without any transfer
  localparam int SETTLE      = 20;     // idle margin after the last expected command is back
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 220;

  // Report fields, lowest bit last
  typedef struct packed {
    logic [5:0]                        pad;
    logic                              driver_faulted;
    logic                              charging;
    logic                              force_full;
    logic                              overtemp_fault;
    logic [7:0]                        usable_sensors;
    logic                              read_fault;
    logic                              temp_ok;
    logic signed [fdt_pkg::TEMP_W-1:0] cell_temp;
  } temp_report_t;

  typedef struct packed {
    logic [2:0]                pad;
    fdt_pkg::reason_t          reason;
    logic [fdt_pkg::CMD_W-1:0] fan_command;
  } fan_result_t;

  // Fan curve predictor and store of expected commands
  class fan_cmd_scoreboard;
    fdt_pkg::cfg_regs_t        regs;
    logic [fdt_pkg::CMD_W-1:0] last_cmd;
    fdt_pkg::reason_t          last_rsn;
    fan_result_t               cmd_q[$];
    int                        errors;

    function new();
      regs.ramp_start_temp     = 12'sd400;
      regs.full_speed_temp     = 12'sd550;
      regs.off_hysteresis      = 9'd30;
      regs.min_command         = 10'd200;
      regs.charge_warm_command = 10'd300;
      last_cmd = fdt_pkg::CMD_OFF;
      last_rsn = fdt_pkg::RS_OFF_COOL;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        fdt_pkg::REG_RAMP_START:  regs.ramp_start_temp     = v[fdt_pkg::TEMP_W-1:0];
        fdt_pkg::REG_FULL_SPEED:  regs.full_speed_temp     = v[fdt_pkg::TEMP_W-1:0];
        fdt_pkg::REG_OFF_HYST:    regs.off_hysteresis      = v[fdt_pkg::HYST_W-1:0];
        fdt_pkg::REG_MIN_CMD:     regs.min_command         = v[fdt_pkg::CMD_W-1:0];
        fdt_pkg::REG_CHARGE_WARM: regs.charge_warm_command = v[fdt_pkg::CMD_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction

    // Work out the command for one accepted report and update the held state
    function void note_report(temp_report_t r);
      int                        t, start_i, full_i, off_i, ramp;
      logic [fdt_pkg::CMD_W-1:0] min_c, warm_c, cmd;
      fdt_pkg::reason_t          rsn;
      logic                      running;
      fan_result_t               res;
      t       = int'(r.cell_temp);
      start_i = int'($signed(regs.ramp_start_temp));
      full_i  = int'($signed(regs.full_speed_temp));
      off_i   = start_i - int'(regs.off_hysteresis);
      min_c   = (regs.min_command > fdt_pkg::CMD_FULL) ? fdt_pkg::CMD_FULL : regs.min_command;
      warm_c  = (regs.charge_warm_command > fdt_pkg::CMD_FULL) ? fdt_pkg::CMD_FULL :
                regs.charge_warm_command;
      if (!r.temp_ok || r.read_fault || r.usable_sensors == 8'd0) begin
        cmd = fdt_pkg::CMD_FULL; rsn = fdt_pkg::RS_INVALID;
      end else if (r.overtemp_fault) begin
        cmd = fdt_pkg::CMD_FULL; rsn = fdt_pkg::RS_FAULT;
      end else if (r.force_full || t >= full_i || full_i <= start_i) begin
        cmd = fdt_pkg::CMD_FULL; rsn = fdt_pkg::RS_HOT_LIMIT;
      end else if (t <= off_i) begin
        cmd = fdt_pkg::CMD_OFF; rsn = fdt_pkg::RS_OFF_COOL;
      end else if (t <= start_i) begin
        // hysteresis band: hold the minimum only if the fan was really running
        running = (last_cmd > fdt_pkg::RUN_THRESH) && last_rsn != fdt_pkg::RS_HOT_LIMIT &&
                  last_rsn != fdt_pkg::RS_INVALID && last_rsn != fdt_pkg::RS_FAULT &&
                  !r.driver_faulted;
        if (running) begin
          cmd = min_c; rsn = fdt_pkg::RS_MIN_HYST;
        end else if (r.charging) begin
          cmd = warm_c; rsn = fdt_pkg::RS_CHARGE_WARM;
        end else begin
          cmd = fdt_pkg::CMD_OFF; rsn = fdt_pkg::RS_OFF_COOL;
        end
      end else begin
        ramp = ((t - start_i) * int'(fdt_pkg::RAMP_SCALE)) / (full_i - start_i);
        if (ramp > int'(fdt_pkg::CMD_FULL)) ramp = int'(fdt_pkg::CMD_FULL);
        cmd = fdt_pkg::CMD_W'(ramp);
        if (cmd < min_c) cmd = min_c;
        if (r.charging && cmd < warm_c) begin
          cmd = warm_c; rsn = fdt_pkg::RS_CHARGE_WARM;
        end else begin
          rsn = fdt_pkg::RS_RAMP;
        end
      end
      last_cmd = cmd;
      last_rsn = rsn;
      res = '0;
      res.fan_command = cmd;
      res.reason      = rsn;
      cmd_q.push_back(res);
    endfunction

    function void check_command(fan_result_t got);
      fan_result_t want;
      if (cmd_q.size() == 0) begin
        $display("%0t: fan command %0d reason %0d with none expected",
                 $time, got.fan_command, got.reason);
        errors++;
        return;
      end
      want = cmd_q.pop_front();
      if (got.fan_command !== want.fan_command) begin
        $display("%0t: fan_command expected %0d actual %0d",
                 $time, want.fan_command, got.fan_command);
        errors++;
      end
      if (got.reason !== want.reason) begin
        $display("%0t: reason expected %0d actual %0d", $time, want.reason, got.reason);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // temp_report_t, cell_temp in the lowest bits
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // fan_result_t, fan_command in the lowest bits

  fan_cmd_scoreboard sb = new();
  int burst_left = 0;
  int rdy_hold = 0;
  int stall_cycles = 0;

  fan_duty_from_temperature_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: free-flowing stretches, long stalls and short jittery spells
  always @(posedge clk) begin
    if (rdy_hold == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b0;
          rdy_hold   <= $urandom_range(1, 12);
        end
        1: begin
          out_tready <= 1'b1;
          rdy_hold   <= $urandom_range(20, 80);
        end
        default: begin
          out_tready <= ($urandom_range(0, 1) == 1);
          rdy_hold   <= $urandom_range(0, 3);
        end
      endcase
    end else begin
      rdy_hold <= rdy_hold - 1;
    end
  end

  // Transfer monitor: note accepted reports, check accepted commands
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_report(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_command(out_tdata);
  end

  // Watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_fan_duty_from_temperature_core failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic temp_report_t mk_report(int t, bit ok, bit rf, int sens, bit of,
                                             bit ff, bit chg, bit drv);
    temp_report_t r;
    r = '0;
    r.cell_temp      = fdt_pkg::TEMP_W'(t);
    r.temp_ok        = ok;
    r.read_fault     = rf;
    r.usable_sensors = 8'(sens);
    r.overtemp_fault = of;
    r.force_full     = ff;
    r.charging       = chg;
    r.driver_faulted = drv;
    return r;
  endfunction

  // Valid report, the common case
  function automatic temp_report_t good_report(int t, bit chg, bit drv);
    return mk_report(t, 1'b1, 1'b0, 8, 1'b0, 1'b0, chg, drv);
  endfunction

  // Random report: temperatures cluster round the curve's break points, spread over the ramp or fall anywhere
  function automatic temp_report_t rand_report();
    int start_i, full_i, off_i, t, jit;
    start_i = int'($signed(sb.regs.ramp_start_temp));
    full_i  = int'($signed(sb.regs.full_speed_temp));
    off_i   = start_i - int'(sb.regs.off_hysteresis);
    jit     = $urandom_range(0, 12) - 6;
    case ($urandom_range(0, 6))
      0: t = off_i + jit;
      1: t = start_i + jit;
      2: t = full_i + jit;
      3, 4: t = (full_i > start_i) ? start_i + $urandom_range(0, full_i - start_i) : start_i + jit;
      5: t = $urandom_range(0, 1900) - 400;
      default: t = $urandom_range(0, 4095);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      // noise: any flag combination
      return mk_report(t, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                       $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1));
    end
    return mk_report(t, 1'b1, 1'b0, $urandom_range(1, 255), 1'b0, ($urandom_range(0, 19) == 0),
                     $urandom_range(0, 1), ($urandom_range(0, 4) == 0));
  endfunction

  // Offer one report and hold it until transferred; bursts end in a random gap
  task automatic send_report(temp_report_t r);
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100) : $urandom_range(0, 8);
    end
  endtask

  // Stop offering and wait until every expected command is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Setup and access phases of a register write, then the bus returns to idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic write_curve(int s, int f, int hyst, int min_c, int warm_c);
    write_reg(fdt_pkg::REG_RAMP_START, {20'd0, fdt_pkg::TEMP_W'(s)});
    write_reg(fdt_pkg::REG_FULL_SPEED, {20'd0, fdt_pkg::TEMP_W'(f)});
    write_reg(fdt_pkg::REG_OFF_HYST, {23'd0, fdt_pkg::HYST_W'(hyst)});
    write_reg(fdt_pkg::REG_MIN_CMD, {22'd0, fdt_pkg::CMD_W'(min_c)});
    write_reg(fdt_pkg::REG_CHARGE_WARM, {22'd0, fdt_pkg::CMD_W'(warm_c)});
  endtask

  // Random curve, extremes now and then, spans mostly positive
  task automatic random_curve();
    int s, f, hyst, min_c, warm_c;
    case ($urandom_range(0, 9))
      0: s = -2048;
      1: s = 2047;
      default: s = $urandom_range(0, 1900) - 400;
    endcase
    case ($urandom_range(0, 9))
      0: f = s;
      1: f = s - $urandom_range(1, 300);
      2: f = 2047;
      3: f = -2048;
      default: f = s + $urandom_range(1, 600);
    endcase
    case ($urandom_range(0, 5))
      0: hyst = 0;
      1: hyst = 511;
      default: hyst = $urandom_range(0, 120);
    endcase
    case ($urandom_range(0, 5))
      0: min_c = 0;
      1: min_c = 1023;
      default: min_c = $urandom_range(0, 1000);
    endcase
    case ($urandom_range(0, 5))
      0: warm_c = 0;
      1: warm_c = 1023;
      default: warm_c = $urandom_range(0, 1000);
    endcase
    write_curve(s, f, hyst, min_c, warm_c);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset curve: 400 start, 550 full, 30 band, 200 minimum, 300 charge floor
    send_report(mk_report(1500, 1'b0, 1'b0, 255, 1'b0, 1'b0, 1'b0, 1'b0)); // data not ok
    send_report(mk_report(400, 1'b1, 1'b1, 255, 1'b1, 1'b1, 1'b1, 1'b1));  // read fault wins
    send_report(mk_report(400, 1'b1, 1'b0, 0, 1'b1, 1'b0, 1'b0, 1'b0));    // no sensors
    send_report(mk_report(400, 1'b1, 1'b0, 255, 1'b1, 1'b1, 1'b0, 1'b0));  // fault over force
    send_report(mk_report(0, 1'b1, 1'b0, 1, 1'b0, 1'b1, 1'b0, 1'b0));      // forced full
    send_report(good_report(550, 1'b0, 1'b0));    // at the full-speed point
    send_report(good_report(2047, 1'b0, 1'b0));
    send_report(good_report(-2048, 1'b1, 1'b0));  // far below: off
    send_report(good_report(380, 1'b0, 1'b0));    // band, was off, not charging
    send_report(good_report(380, 1'b1, 1'b0));    // band while charging: warm level
    send_report(good_report(380, 1'b0, 1'b0));    // was running: hold the minimum
    send_report(good_report(400, 1'b0, 1'b1));    // driver fault: not running
    send_report(good_report(401, 1'b0, 1'b0));    // ramp floored at the minimum
    send_report(good_report(371, 1'b0, 1'b0));    // just inside the band
    send_report(good_report(370, 1'b0, 1'b0));    // on the off point
    send_report(good_report(410, 1'b1, 1'b0));    // ramp lifted to the charge floor
    send_report(good_report(549, 1'b1, 1'b0));
    send_report(good_report(600, 1'b0, 1'b0));    // full speed ...
    send_report(good_report(390, 1'b0, 1'b0));    // ... does not count as running
    wait_idle();

    // Saturated floors and the widest band
    write_curve(0, 1000, 511, 1023, 1020);
    send_report(good_report(10, 1'b0, 1'b0));
    send_report(good_report(-5, 1'b0, 1'b0));
    send_report(good_report(-5, 1'b1, 1'b1));
    send_report(good_report(-511, 1'b1, 1'b0));
    wait_idle();

    // Widest span, no band, zero floors
    write_curve(-2048, 2047, 0, 0, 0);
    send_report(good_report(2046, 1'b0, 1'b0));
    send_report(good_report(-2047, 1'b1, 1'b0));
    send_report(good_report(-2048, 1'b0, 1'b0));
    wait_idle();

    // Zero and negative span force full speed
    write_reg(fdt_pkg::REG_FULL_SPEED, {20'd0, fdt_pkg::TEMP_W'(-2048)});
    send_report(good_report(-2048, 1'b0, 1'b0));
    wait_idle();
    write_reg(fdt_pkg::REG_RAMP_START, {20'd0, fdt_pkg::TEMP_W'(2047)});
    send_report(good_report(0, 1'b1, 1'b0));
    wait_idle();

    // Random phases, each on a fresh curve
    for (int p = 0; p < PHASES; p++) begin
      random_curve();
      for (int i = 0; i < PHASE_ITEMS; i++) send_report(rand_report());
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("tb_fan_duty_from_temperature_core passed");
    end else begin
      $display("tb_fan_duty_from_temperature_core failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/fdt_pkg.sv
src/fdt_cfg_regs.sv
src/fdt_div.sv
src/fan_duty_from_temperature_core.sv
bench/tb_fan_duty_from_temperature_core.sv
